### hw/rtl/hpst_pkg.sv
package hpst_pkg;

  localparam int KEY_W  = 64;
  localparam int SEC_W  = 32;
  localparam int CNT_W  = 32;
  localparam int VAL_W  = 31;
  localparam int IN_W   = 64;
  localparam int OUT_W  = 40;
  localparam int RES_W  = CNT_W + 2;

  localparam logic [KEY_W-1:0] FNV_BASIS   = 64'hCBF2_9CE4_8422_2325;
  localparam logic [CNT_W-1:0] LIMIT_RESET = 32'd100;
  localparam logic [CNT_W-1:0] COUNT_MAX   = 32'hFFFF_FFFF;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_SEC = 4'd1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SEC_W-1:0] sec;
    logic [CNT_W-1:0] count;
  } bucket_t;

  // suppress sits in bit 0
  typedef struct packed {
    logic [CNT_W-1:0] evicted_suppressed;
    logic             first_suppressed;
    logic             suppress;
  } result_t;

  // multiply by the fnv prime 2^40 + 435, modulo 2^64
  function automatic logic [KEY_W-1:0] fnv_mul(input logic [KEY_W-1:0] x);
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

### hw/rtl/hpst_bucket_index.sv
module hpst_bucket_index
  import hpst_pkg::*;
#(
  parameter int BUCKETS = 256,
  localparam int IdxW = $clog2(BUCKETS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [IdxW-1:0]  idx_o
);

  localparam bit IsPow2 = (BUCKETS & (BUCKETS - 1)) == 0;

  if (IsPow2) begin : g_mask
    logic            done_q;
    logic [IdxW-1:0] rem_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
        rem_q  <= '0;
      end else begin
        done_q <= start_i;
        if (start_i) begin
          rem_q <= key_i[IdxW-1:0];
        end
      end
    end

    assign done_o = done_q;
    assign idx_o  = rem_q;
  end else begin : g_recip
    // fold the 16-bit chunks by their weights mod BUCKETS, then divide the
    // small sum by a reciprocal multiply; sum, quotient and remainder are each registered
    localparam int SumW  = 30;
    localparam int Shift = SumW + IdxW;
    localparam int ProdW = Shift + SumW;
    localparam logic [SumW-1:0] Wt1 = SumW'((64'd1 << 16) % 64'(BUCKETS));
    localparam logic [SumW-1:0] Wt2 = SumW'((64'd1 << 32) % 64'(BUCKETS));
    localparam logic [SumW-1:0] Wt3 = SumW'((64'd1 << 48) % 64'(BUCKETS));
    localparam logic [SumW:0]   Recip =
      (SumW + 1)'(((64'd1 << Shift) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

    logic             st1_q;
    logic             st2_q;
    logic             done_q;
    logic [SumW-1:0]  sum_q;
    logic [SumW-1:0]  quo_q;
    logic [IdxW-1:0]  rem_q;
    logic [SumW-1:0]  fold;
    logic [ProdW-1:0] prod;
    logic [SumW-1:0]  rem_full;

    assign fold = SumW'(key_i[15:0]) + SumW'(key_i[31:16]) * Wt1
                + SumW'(key_i[47:32]) * Wt2 + SumW'(key_i[63:48]) * Wt3;
    assign prod     = ProdW'(sum_q) * ProdW'(Recip);
    assign rem_full = sum_q - quo_q * SumW'(BUCKETS);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st1_q  <= 1'b0;
        st2_q  <= 1'b0;
        done_q <= 1'b0;
        sum_q  <= '0;
        quo_q  <= '0;
        rem_q  <= '0;
      end else begin
        st1_q  <= start_i;
        st2_q  <= st1_q;
        done_q <= st2_q;
        if (start_i) begin
          sum_q <= fold;
        end
        if (st1_q) begin
          quo_q <= prod[Shift +: SumW];
        end
        if (st2_q) begin
          rem_q <= rem_full[IdxW-1:0];
        end
      end
    end

    assign done_o = done_q;
    assign idx_o  = rem_q;
  end

endmodule

### hw/rtl/hashed_per_second_throttle.sv
// absorb item: one per cycle while idle, hashed in the cycle taken, no result
// decide item: index, bucket read, update, result; the remainder unit adds its
//   sum and quotient stages to the index step when BUCKETS is not a power of two
// disabled decide: result only; a result may wait in the output register
// reset: async active low; a clearing pass zeroes the bucket memory before the
//   first item is taken, config writes are taken during it
module hashed_per_second_throttle
  import hpst_pkg::*;
#(
  parameter int BUCKETS = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [IN_W-1:0]      s_axis_tdata,  // value [30:0], now_sec [62:31], zero pad
  input  logic                 s_axis_tuser,  // command: 0 absorb, 1 decide
  // result stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_W-1:0]     m_axis_tdata,  // suppress [0], first_suppressed [1],
                                              // evicted_suppressed [33:2], zero pad
  // configuration writes
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CNT_W-1:0]     cfg_data_i
);

  localparam int IdxW = $clog2(BUCKETS);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INDEX,
    ST_UPDATE,
    ST_EMIT
  } state_e;

  state_e           state_q;
  logic [IdxW-1:0]  clr_q;
  logic [KEY_W-1:0] hash_q;
  logic [KEY_W-1:0] key_q;
  logic [SEC_W-1:0] now_q;
  logic [IdxW-1:0]  idx_q;
  result_t          res_q;
  result_t          out_q;
  logic             m_valid_q;
  logic             enable_q;
  logic [CNT_W-1:0] limit_q;

  logic             in_acc;
  logic [VAL_W-1:0] in_value;
  logic [SEC_W-1:0] in_now;
  logic             idx_start;
  logic             idx_done;
  logic [IdxW-1:0]  idx_val;

  // bucket memory, one read port and one write port
  bucket_t          bucket_mem [BUCKETS];
  bucket_t          rd_q;
  logic             mem_re;
  logic             mem_we;
  logic [IdxW-1:0]  mem_waddr;
  bucket_t          mem_wdata;

  bucket_t          upd_bucket;
  result_t          upd_res;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_value      = s_axis_tdata[VAL_W-1:0];
  assign in_now        = s_axis_tdata[VAL_W+SEC_W-1:VAL_W];
  assign idx_start     = in_acc && s_axis_tuser && enable_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {(OUT_W - RES_W)'(0), out_q};
  assign cfg_ready_o   = 1'b1;

  // bucket index = hash mod BUCKETS
  hpst_bucket_index #(
    .BUCKETS(BUCKETS)
  ) u_index (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(idx_start),
    .key_i  (hash_q),
    .done_o (idx_done),
    .idx_o  (idx_val)
  );

  // read as soon as the index is known, write back in the next cycle
  assign mem_re    = (state_q == ST_INDEX) && idx_done;
  assign mem_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : idx_q;
  assign mem_wdata = (state_q == ST_CLEAR) ? '0 : upd_bucket;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bucket_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= bucket_mem[idx_val];
    end
  end

  // bucket update rules
  always_comb begin
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] over;
    logic [CNT_W-1:0] over_inc;
    cnt_inc  = (rd_q.count == COUNT_MAX) ? COUNT_MAX : rd_q.count + 1'b1;
    over     = rd_q.count - limit_q;
    over_inc = cnt_inc - limit_q;
    upd_bucket = rd_q;
    upd_res    = '0;
    if (rd_q.sec != now_q) begin
      // new second: start the bucket over, nothing reported
      upd_bucket.sec   = now_q;
      upd_bucket.key   = key_q;
      upd_bucket.count = CNT_W'(1);
    end else if (rd_q.key == key_q) begin
      upd_bucket.count = cnt_inc;
      if (rd_q.count >= limit_q) begin
        upd_res.suppress         = 1'b1;
        upd_res.first_suppressed = (over_inc == CNT_W'(1));
      end
    end else begin
      // collision within the second: take over the bucket, report the old key's suppressed count
      upd_bucket.key   = key_q;
      upd_bucket.count = CNT_W'(1);
      if (rd_q.count > limit_q) begin
        upd_res.evicted_suppressed = over;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      limit_q  <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLE: begin
          enable_q <= cfg_data_i[0];
        end
        REG_MAX_PER_SEC: begin
          // a zero limit is ignored
          if (cfg_data_i != '0) begin
            limit_q <= cfg_data_i;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer, running hash and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      hash_q    <= FNV_BASIS;
      key_q     <= '0;
      now_q     <= '0;
      idx_q     <= '0;
      res_q     <= '0;
      out_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // the emit state refills the output register itself
      if (m_valid_q && m_axis_tready && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdxW'(BUCKETS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (!s_axis_tuser) begin
              hash_q <= fnv_mul(hash_q ^ {(KEY_W - VAL_W)'(0), in_value});
            end else begin
              // every decide closes the message
              hash_q <= FNV_BASIS;
              key_q  <= hash_q;
              now_q  <= in_now;
              if (enable_q) begin
                state_q <= ST_INDEX;
              end else begin
                res_q   <= '0;
                state_q <= ST_EMIT;
              end
            end
          end
        end
        ST_INDEX: begin
          if (idx_done) begin
            idx_q   <= idx_val;
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          res_q   <= upd_res;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            out_q     <= res_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // checks
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
    else $error("bucket write outside clear or update");

  a_hash_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser) |=> (hash_q == FNV_BASIS))
    else $error("hash not restarted after decide");

  a_first_implies_sup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (!out_q.first_suppressed || out_q.suppress))
    else $error("first_suppressed without suppress");

  a_sup_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && out_q.suppress) |-> (out_q.evicted_suppressed == '0))
    else $error("suppressed item reports an eviction");

  a_limit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_q != '0)
    else $error("limit register is zero");

endmodule
